// ----- hdl/tlik_pkg.sv -----
// Shared widths, constants, register codes and helper functions for the
// two-link leg inverse kinematics block. No dependencies.
package tlik_pkg;

   localparam int COORD_W  = 24;   // hand and base coordinates, Q16.8
   localparam int DIFF_W   = 25;   // base-relative offsets
   localparam int ROOT_W   = 25;   // hand distance
   localparam int SQ_W     = 2 * ROOT_W;
   localparam int LEN_W    = 23;   // link lengths
   localparam int NUM_W    = 52;   // law-of-cosines numerator
   localparam int DEN_W    = 50;   // law-of-cosines denominator
   localparam int DIV_STEPS = 30;
   localparam int DIV_LAT  = DIV_STEPS + 2;
   localparam int DIVN_W   = 33;   // normalized divisor
   localparam int C_W      = 32;   // cosine ratio, Q30
   localparam int SIDE_W   = 31;   // sine side, Q30
   localparam int RAD_W    = 2 * SIDE_W;
   localparam int ANG_W    = 18;   // internal angle, Q.12 radians
   localparam int CORD_W   = 34;   // CORDIC datapath
   localparam int PROD_W   = 58;   // link length times sine
   localparam int ELB_W    = 27;   // elbow coordinates
   localparam int OUT_W    = 15;   // result angle, Q3.12
   localparam int NORM_TOP = 29;   // vectoring normalizes to this msb
   localparam int CORDIC_MAX = 24;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int PADDR_W  = 5;
   localparam int PDATA_W  = 32;

   typedef logic signed [ANG_W-1:0] angle_type;

   localparam angle_type PI_ANG      = 18'sd12867;
   localparam angle_type HALF_PI_ANG = 18'sd6433;
   localparam logic signed [CORD_W-1:0] GAIN_INV = 34'sd652032874;
   localparam logic signed [C_W-1:0]    ONE_Q30  = 32'sd1073741824;

   localparam logic [2:0] REG_BASE_X    = 3'd0;
   localparam logic [2:0] REG_BASE_Y    = 3'd1;
   localparam logic [2:0] REG_UPPER_LEN = 3'd2;
   localparam logic [2:0] REG_FORE_LEN  = 3'd3;
   localparam logic [2:0] REG_ANGLE_MAX = 3'd4;
   localparam logic [2:0] REG_ANGLE_MIN = 3'd5;

   localparam logic [LEN_W-1:0]        LEN_RESET       = 23'd25600;
   localparam logic signed [OUT_W-1:0] ANGLE_MAX_RESET = 15'sd12868;
   localparam logic signed [OUT_W-1:0] ANGLE_MIN_RESET = -15'sd12868;

   // atan(2^-i) in the internal angle format
   function automatic angle_type atan_tab(input int i);
      angle_type t;
      case (i)
         0:       t = 18'sd3216;
         1:       t = 18'sd1899;
         2:       t = 18'sd1003;
         3:       t = 18'sd509;
         4:       t = 18'sd255;
         5:       t = 18'sd127;
         6:       t = 18'sd63;
         7:       t = 18'sd31;
         8:       t = 18'sd15;
         9:       t = 18'sd7;
         10:      t = 18'sd3;
         11:      t = 18'sd1;
         default: t = 18'sd0;
      endcase
      return t;
   endfunction

   // position of the highest set bit, zero for zero
   function automatic logic [5:0] msb_pos(input logic [63:0] v);
      logic [5:0] p;
      p = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) p = 6'(i);
      end
      return p;
   endfunction

endpackage

// ----- hdl/tlik_delay.sv -----
// Enabled shift line that keeps sideband data aligned with the pipeline.
// No dependencies besides the package.
module tlik_delay import tlik_pkg::*; #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1,
   parameter bit CLEAR = 1'b0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);
   logic [WIDTH-1:0] pipe_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (CLEAR && reset) begin
         // drop everything in flight so valid bits start out low
         for (int i = 0; i < DEPTH; i++) pipe_ff[i] <= '0;
      end else if (en) begin
         pipe_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) pipe_ff[i] <= pipe_ff[i-1];
      end
   end

   assign dout = pipe_ff[DEPTH-1];
endmodule

// ----- hdl/tlik_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, truncating.
// Uses the tlik package.
module tlik_sqrt import tlik_pkg::*; #(
   parameter int ROOT_BITS = ROOT_W
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [2*ROOT_BITS-1:0]   rad_in,
   output logic [ROOT_BITS-1:0]     root_out
);
   localparam int RB = 2 * ROOT_BITS;

   logic [RB-1:0]        rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS];

   for (genvar s = 0; s < ROOT_BITS; s++) begin : g_stage
      localparam int B = ROOT_BITS - 1 - s;
      logic [RB-1:0]        rem_prev;
      logic [ROOT_BITS-1:0] root_prev;
      logic [RB:0]          trial;

      if (s == 0) begin : g_first
         assign rem_prev  = rad_in;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
      end

      assign trial = ({{(RB+1-ROOT_BITS){1'b0}}, root_prev} << (B + 1))
                   | ((RB+1)'(1) << (2 * B));

      always_ff @(posedge clock) begin
         if (en) begin
            if ({1'b0, rem_prev} >= trial) begin
               rem_ff[s]  <= rem_prev - trial[RB-1:0];
               root_ff[s] <= root_prev | (ROOT_BITS'(1) << B);
            end else begin
               rem_ff[s]  <= rem_prev;
               root_ff[s] <= root_prev;
            end
         end
      end
   end

   assign root_out = root_ff[ROOT_BITS-1];
endmodule

// ----- hdl/tlik_div.sv -----
// Pipelined cosine ratio: num / den in Q30, saturated to [-1, 1].
// Restoring division, one quotient bit per stage. Uses the tlik package.
module tlik_div import tlik_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [NUM_W-1:0] num_in,
   input  logic [DEN_W-1:0]        den_in,
   output logic signed [C_W-1:0]   ratio_out
);
   logic              sat_ff [DIV_STEPS+1];
   logic              neg_ff [DIV_STEPS+1];
   logic [DIVN_W:0]   rem_ff [DIV_STEPS+1];
   logic [DIVN_W-1:0] den_ff [DIV_STEPS+1];
   logic [DIV_STEPS:0] quo_ff [DIV_STEPS+1];
   logic signed [C_W-1:0] ratio_ff;

   logic                    neg_in, sat_in, qtop;
   logic [NUM_W-1:0]        mag;
   logic signed [NUM_W-1:0] den_s;
   logic [5:0]              p, k;
   logic [DEN_W-1:0]        den_sh;
   logic [NUM_W-1:0]        mag_sh;
   logic [DIVN_W-1:0]       dn, mn;

   always_comb begin
      neg_in = num_in[NUM_W-1];
      mag    = neg_in ? NUM_W'(-num_in) : NUM_W'(num_in);
      den_s  = $signed({{(NUM_W-DEN_W){1'b0}}, den_in});
      sat_in = (den_in == '0) || (num_in >= den_s) || (num_in <= -den_s);
      p      = msb_pos({{(64-DEN_W){1'b0}}, den_in});
      // scale down so the divisor fits the divider width
      k      = (p >= 6'(DIVN_W)) ? p - 6'(DIVN_W - 1) : 6'd0;
      den_sh = den_in >> k;
      mag_sh = mag >> k;
      dn     = den_sh[DIVN_W-1:0];
      mn     = mag_sh[DIVN_W-1:0];
      qtop   = mn >= dn;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sat_ff[0] <= sat_in;
         neg_ff[0] <= neg_in;
         den_ff[0] <= dn;
         rem_ff[0] <= qtop ? {1'b0, mn - dn} : {1'b0, mn};
         quo_ff[0] <= {{DIV_STEPS{1'b0}}, qtop};
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
      logic [DIVN_W:0] r2;
      assign r2 = {rem_ff[j][DIVN_W-1:0], 1'b0};
      always_ff @(posedge clock) begin
         if (en) begin
            sat_ff[j+1] <= sat_ff[j];
            neg_ff[j+1] <= neg_ff[j];
            den_ff[j+1] <= den_ff[j];
            if (r2 >= {1'b0, den_ff[j]}) begin
               rem_ff[j+1] <= r2 - {1'b0, den_ff[j]};
               quo_ff[j+1] <= {quo_ff[j][DIV_STEPS-1:0], 1'b1};
            end else begin
               rem_ff[j+1] <= r2;
               quo_ff[j+1] <= {quo_ff[j][DIV_STEPS-1:0], 1'b0};
            end
         end
      end
   end

   logic signed [C_W-1:0] q_s;
   assign q_s = $signed({1'b0, quo_ff[DIV_STEPS]});

   always_ff @(posedge clock) begin
      if (en) begin
         if (sat_ff[DIV_STEPS]) ratio_ff <= neg_ff[DIV_STEPS] ? -ONE_Q30 : ONE_Q30;
         else                   ratio_ff <= neg_ff[DIV_STEPS] ? -q_s : q_s;
      end
   end

   assign ratio_out = ratio_ff;
endmodule

// ----- hdl/tlik_vec.sv -----
// Pipelined vectoring CORDIC: atan2(y, x) in the internal angle format.
// One prerotate/normalize stage, then one stage per iteration. Uses the tlik package.
module tlik_vec import tlik_pkg::*; #(
   parameter int IN_W  = 26,
   parameter int STEPS = CORDIC_STEPS_DEF
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic signed [IN_W-1:0] y_in,
   input  logic signed [IN_W-1:0] x_in,
   output angle_type              angle_out
);
   logic signed [CORD_W-1:0] x_ff [STEPS+1];
   logic signed [CORD_W-1:0] y_ff [STEPS+1];
   angle_type                z_ff [STEPS+1];
   logic                     zero_ff [STEPS+1];

   logic signed [CORD_W-1:0] xs, ys, xa, ya, ma, mb, mx;
   angle_type                z0;
   logic [5:0]               p, k;

   always_comb begin
      xs = CORD_W'(x_in);
      ys = CORD_W'(y_in);
      if (xs < 0) begin
         // turn the vector by pi into the right half plane
         xa = -xs;
         ya = -ys;
         z0 = (ys >= 0) ? PI_ANG : -PI_ANG;
      end else begin
         xa = xs;
         ya = ys;
         z0 = '0;
      end
      ma = (xa < 0) ? -xa : xa;
      mb = (ya < 0) ? -ya : ya;
      mx = (ma > mb) ? ma : mb;
      p  = msb_pos({{(64-CORD_W){1'b0}}, mx});
      k  = (p >= 6'(NORM_TOP)) ? 6'd0 : 6'(NORM_TOP) - p;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= xa <<< k;
         y_ff[0]    <= ya <<< k;
         z_ff[0]    <= z0;
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_iter
      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_tab(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_tab(i);
            end
         end
      end
   end

   assign angle_out = zero_ff[STEPS] ? '0 : z_ff[STEPS];
endmodule

// ----- hdl/tlik_rot.sv -----
// Pipelined rotation CORDIC: sine and cosine (Q30) of an internal-format angle.
// Range reduction stage, one stage per iteration, sign fix stage. Uses the tlik package.
module tlik_rot import tlik_pkg::*; #(
   parameter int STEPS = CORDIC_STEPS_DEF
) (
   input  logic                     clock,
   input  logic                     en,
   input  angle_type                phi_in,
   output logic signed [CORD_W-1:0] sin_out,
   output logic signed [CORD_W-1:0] cos_out
);
   logic signed [CORD_W-1:0] x_ff [STEPS+1];
   logic signed [CORD_W-1:0] y_ff [STEPS+1];
   angle_type                p_ff [STEPS+1];
   logic                     neg_ff [STEPS+1];
   logic signed [CORD_W-1:0] sin_ff, cos_ff;

   angle_type p;
   logic      neg;

   always_comb begin
      p = phi_in;
      if (p > PI_ANG) p = p - (PI_ANG <<< 1);
      if (p > PI_ANG) p = p - (PI_ANG <<< 1);
      if (p < -PI_ANG) p = p + (PI_ANG <<< 1);
      if (p < -PI_ANG) p = p + (PI_ANG <<< 1);
      neg = 1'b0;
      // fold into the half plane where the iterations converge
      if (p > HALF_PI_ANG) begin
         p   = p - PI_ANG;
         neg = 1'b1;
      end else if (p < -HALF_PI_ANG) begin
         p   = p + PI_ANG;
         neg = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]   <= GAIN_INV;
         y_ff[0]   <= '0;
         p_ff[0]   <= p;
         neg_ff[0] <= neg;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_iter
      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[i+1] <= neg_ff[i];
            if (p_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               p_ff[i+1] <= p_ff[i] - atan_tab(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               p_ff[i+1] <= p_ff[i] + atan_tab(i);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= neg_ff[STEPS] ? -x_ff[STEPS] : x_ff[STEPS];
         sin_ff <= neg_ff[STEPS] ? -y_ff[STEPS] : y_ff[STEPS];
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;
endmodule

// ----- hdl/two_link_leg_inverse_kinematics_top.sv -----
// Two-link leg inverse kinematics: one base joint angle per target hand point.
// Fully pipelined; takes one transaction per clock while no result is stalled,
// and returns each result in order. Its path runs through the two bit-serial
// square root pipelines, the 30-step divider for the cosine ratio and three
// CORDIC chains in series. A stalled result holds the whole pipeline, and
// req_stall is raised only in that case. The configuration registers are read
// live by the stages that use them, so write them only while no transaction is
// in flight. Depends on tlik_pkg and the tlik_* units.
module two_link_leg_inverse_kinematics_top import tlik_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_hand_x,
   input  logic signed [COORD_W-1:0] req_hand_y,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [OUT_W-1:0]   rsp_base_angle,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [PADDR_W-1:0]        paddr,
   input  logic [PDATA_W-1:0]        pwdata,
   output logic [PDATA_W-1:0]        prdata,
   output logic                      pready
);
   localparam int S      = CORDIC_STEPS;
   localparam int T_H    = 4 + ROOT_W;
   localparam int T_C    = T_H + 2 + DIV_LAT;
   localparam int T_SIDE = T_C + 2 + SIDE_W;
   localparam int T_HAND = T_SIDE + 1 + S;
   localparam int T_FORE = 3 + S;
   localparam int T_PHI  = T_HAND + 1;
   localparam int T_SC   = T_PHI + 2 + S;
   localparam int T_E1   = T_SC + 1;
   localparam int T_A    = T_E1 + 3 + S;

   // configuration
   logic signed [COORD_W-1:0] base_x_ff, base_y_ff;
   logic [LEN_W-1:0]          upper_len_ff, fore_len_ff;
   logic signed [OUT_W-1:0]   angle_max_ff, angle_min_ff;
   logic                      csr_write;
   logic [2:0]                csr_index;

   assign pready    = 1'b1;
   assign csr_index = paddr[PADDR_W-1:2];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_x_ff    <= '0;
         base_y_ff    <= '0;
         upper_len_ff <= LEN_RESET;
         fore_len_ff  <= LEN_RESET;
         angle_max_ff <= ANGLE_MAX_RESET;
         angle_min_ff <= ANGLE_MIN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_BASE_X:    base_x_ff    <= pwdata[COORD_W-1:0];
            REG_BASE_Y:    base_y_ff    <= pwdata[COORD_W-1:0];
            REG_UPPER_LEN: upper_len_ff <= pwdata[LEN_W-1:0];
            REG_FORE_LEN:  fore_len_ff  <= pwdata[LEN_W-1:0];
            REG_ANGLE_MAX: angle_max_ff <= pwdata[OUT_W-1:0];
            REG_ANGLE_MIN: angle_min_ff <= pwdata[OUT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_BASE_X:    prdata = {{(PDATA_W-COORD_W){1'b0}}, base_x_ff};
         REG_BASE_Y:    prdata = {{(PDATA_W-COORD_W){1'b0}}, base_y_ff};
         REG_UPPER_LEN: prdata = {{(PDATA_W-LEN_W){1'b0}}, upper_len_ff};
         REG_FORE_LEN:  prdata = {{(PDATA_W-LEN_W){1'b0}}, fore_len_ff};
         REG_ANGLE_MAX: prdata = {{(PDATA_W-OUT_W){1'b0}}, angle_max_ff};
         REG_ANGLE_MIN: prdata = {{(PDATA_W-OUT_W){1'b0}}, angle_min_ff};
         default:       prdata = '0;
      endcase
   end

   // pipeline advance: hold everything while the result waits
   logic en;
   logic rsp_valid_ff;
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // hand point and offsets
   logic                       v1_ff;
   logic signed [COORD_W-1:0]  hx1_ff, hy1_ff;
   logic signed [DIFF_W-1:0]   dx2_ff, dy2_ff;
   logic [SQ_W-1:0]            dxx3_ff, dyy3_ff, sum4_ff;
   logic signed [SQ_W-1:0]     dxx_w, dyy_w;

   assign dxx_w = dx2_ff * dx2_ff;
   assign dyy_w = dy2_ff * dy2_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hx1_ff  <= req_hand_x;
         hy1_ff  <= req_hand_y;
         dx2_ff  <= DIFF_W'(hx1_ff) - DIFF_W'(base_x_ff);
         dy2_ff  <= DIFF_W'(hy1_ff) - DIFF_W'(base_y_ff);
         dxx3_ff <= dxx_w;
         dyy3_ff <= dyy_w;
         sum4_ff <= dxx3_ff + dyy3_ff;
      end
   end

   // hand distance
   logic [ROOT_W-1:0] h;
   tlik_sqrt #(.ROOT_BITS(ROOT_W)) u_sqrt_h (
      .clock(clock), .en(en), .rad_in(sum4_ff), .root_out(h)
   );

   // fore angle atan2(dx, -dy)
   angle_type a_fore, a_fore_d;
   tlik_vec #(.IN_W(DIFF_W+1), .STEPS(S)) u_vec_fore (
      .clock(clock), .en(en),
      .y_in((DIFF_W+1)'(dx2_ff)),
      .x_in(-((DIFF_W+1)'(dy2_ff))),
      .angle_out(a_fore)
   );
   tlik_delay #(.WIDTH(ANG_W), .DEPTH(T_HAND - T_FORE)) u_dly_fore (
      .clock(clock), .reset(reset), .en(en), .din(a_fore), .dout(a_fore_d)
   );

   // law of cosines
   logic [SQ_W-1:0]          hh_ff;
   logic [ROOT_W+LEN_W-1:0]  hf_ff;
   logic [2*LEN_W-1:0]       ff_ff, uu_ff;
   logic signed [NUM_W-1:0]  num_ff;
   logic [DEN_W-1:0]         den_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         hh_ff  <= h * h;
         hf_ff  <= h * fore_len_ff;
         ff_ff  <= fore_len_ff * fore_len_ff;
         uu_ff  <= upper_len_ff * upper_len_ff;
         num_ff <= $signed(NUM_W'(hh_ff)) + $signed(NUM_W'(ff_ff))
                 - $signed(NUM_W'(uu_ff));
         den_ff <= DEN_W'({hf_ff, 1'b0});
      end
   end

   logic signed [C_W-1:0] c, c_d;
   tlik_div u_div (
      .clock(clock), .en(en), .num_in(num_ff), .den_in(den_ff), .ratio_out(c)
   );
   tlik_delay #(.WIDTH(C_W), .DEPTH(T_SIDE - T_C)) u_dly_c (
      .clock(clock), .reset(reset), .en(en), .din(c), .dout(c_d)
   );

   // sine side sqrt(1 - c^2)
   logic [SIDE_W-1:0] c_mag;
   logic [RAD_W-1:0]  cc_ff, rad_ff;
   logic [SIDE_W-1:0] side;

   assign c_mag = c[C_W-1] ? SIDE_W'(-c) : SIDE_W'(c);

   always_ff @(posedge clock) begin
      if (en) begin
         cc_ff  <= c_mag * c_mag;
         rad_ff <= (RAD_W'(1) << 60) - cc_ff;
      end
   end

   tlik_sqrt #(.ROOT_BITS(SIDE_W)) u_sqrt_side (
      .clock(clock), .en(en), .rad_in(rad_ff), .root_out(side)
   );

   angle_type a_hand;
   tlik_vec #(.IN_W(C_W), .STEPS(S)) u_vec_hand (
      .clock(clock), .en(en),
      .y_in($signed({1'b0, side})), .x_in(c_d), .angle_out(a_hand)
   );

   // elbow
   angle_type phi_ff;
   always_ff @(posedge clock) begin
      if (en) phi_ff <= a_fore_d - a_hand;
   end

   logic signed [CORD_W-1:0] sn, cs;
   tlik_rot #(.STEPS(S)) u_rot (
      .clock(clock), .en(en), .phi_in(phi_ff), .sin_out(sn), .cos_out(cs)
   );

   logic signed [COORD_W-1:0]  hx_d, hy_d;
   tlik_delay #(.WIDTH(2*COORD_W), .DEPTH(T_E1 - 1)) u_dly_hand (
      .clock(clock), .reset(reset), .en(en), .din({hx1_ff, hy1_ff}),
      .dout({hx_d, hy_d})
   );

   logic signed [PROD_W-1:0] ps_ff, pc_ff, ps_r, pc_r;
   logic signed [ELB_W-1:0]  ex_ff, ey_ff, ex3_ff, ey3_ff;

   // round half up to whole Q16.8 units
   assign ps_r = (ps_ff + (PROD_W'(1) <<< 29)) >>> 30;
   assign pc_r = (pc_ff + (PROD_W'(1) <<< 29)) >>> 30;

   always_ff @(posedge clock) begin
      if (en) begin
         ps_ff  <= $signed({1'b0, fore_len_ff}) * sn;
         pc_ff  <= $signed({1'b0, fore_len_ff}) * cs;
         ex_ff  <= ELB_W'(hx_d) - ps_r[ELB_W-1:0];
         ey_ff  <= ELB_W'(hy_d) + pc_r[ELB_W-1:0];
         ex3_ff <= ex_ff - ELB_W'(base_x_ff);
         ey3_ff <= ey_ff - ELB_W'(base_y_ff);
      end
   end

   angle_type a_base;
   tlik_vec #(.IN_W(ELB_W), .STEPS(S)) u_vec_base (
      .clock(clock), .en(en), .y_in(ey3_ff), .x_in(ex3_ff), .angle_out(a_base)
   );

   // valid travels alongside the data
   logic v_d;
   tlik_delay #(.WIDTH(1), .DEPTH(T_A - 1), .CLEAR(1'b1)) u_dly_valid (
      .clock(clock), .reset(reset), .en(en), .din(v1_ff), .dout(v_d)
   );

   // clamp and output register; the upper limit wins when limits are inverted
   angle_type amax, amin;
   logic signed [OUT_W-1:0] angle_ff;
   assign amax = ANG_W'(angle_max_ff);
   assign amin = ANG_W'(angle_min_ff);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= v_d;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (a_base > amax)      angle_ff <= angle_max_ff;
         else if (a_base < amin) angle_ff <= angle_min_ff;
         else                    angle_ff <= a_base[OUT_W-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_base_angle = angle_ff;
endmodule

// ----- hdl/tlik_checker.sv -----
// Port-level checks for the inverse kinematics block, bound to its top level.
// Depends on tlik_pkg and two_link_leg_inverse_kinematics_top.
module tlik_checker import tlik_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic signed [OUT_W-1:0]   rsp_base_angle,
   input logic                      pready
);
   // input back-pressure comes only from a stalled result
   a_stall_cause: assert property (@(posedge clock)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_base_angle))
      else $error("stalled result changed");

   a_pready_high: assert property (@(posedge clock) pready)
      else $error("pready dropped");
endmodule

bind two_link_leg_inverse_kinematics_top tlik_checker u_tlik_checker (.*);

// ----- verif/ik_checker.sv -----
// Checker for the two-link leg inverse kinematics block: tracks register writes,
// predicts the base angle of every accepted hand point and compares results.
// Depends on tlik_pkg for port widths and register codes.
module ik_checker import tlik_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_hand_x,
   input  logic signed [COORD_W-1:0] req_hand_y,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic signed [OUT_W-1:0]   rsp_base_angle,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic                      pready,
   input  logic [PADDR_W-1:0]        paddr,
   input  logic [PDATA_W-1:0]        pwdata,
   output int                        errors,
   output int                        pending,
   output int                        checked
);

   localparam int STEPS = 16;
   localparam longint PI_Q30_L   = 64'sd3373259426;
   localparam longint HALF_PI_L  = 64'sd1686629713;
   localparam longint GAIN_Q30   = 64'sd652032874;
   localparam longint UNIT_Q30   = 64'sd1073741824;

   longint atan_q30 [24] = '{
      64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158, 64'sd67021686,
      64'sd33543515, 64'sd16775850, 64'sd8388437, 64'sd4194282, 64'sd2097149,
      64'sd1048575, 64'sd524287, 64'sd262143, 64'sd131071, 64'sd65535, 64'sd32767,
      64'sd16383, 64'sd8191, 64'sd4095, 64'sd2047, 64'sd1023, 64'sd511, 64'sd255,
      64'sd127};

   longint base_x, base_y, upper_len, fore_len, angle_hi, angle_lo;
   logic signed [OUT_W-1:0] angle_q [$];
   int reports;

   function automatic longint sqrt_floor(input longint v);
      longint r, b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   function automatic longint mag(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // atan2(y, x) in radians Q.12
   function automatic longint atan2_q12(input longint y, input longint x);
      longint z, nx, ny, pi_a;
      z = 0;
      pi_a = PI_Q30_L >>> 18;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? pi_a : -pi_a;
         x = -x;
         y = -y;
      end
      while (((mag(x) > mag(y)) ? mag(x) : mag(y)) < (64'sd1 <<< 29)) begin
         x = x * 2;
         y = y * 2;
      end
      for (int i = 0; i < STEPS; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i); ny = y - (x >>> i); z = z + (atan_q30[i] >>> 18);
         end else begin
            nx = x - (y >>> i); ny = y + (x >>> i); z = z - (atan_q30[i] >>> 18);
         end
         x = nx;
         y = ny;
      end
      return z;
   endfunction

   // sin and cos in Q30 of a Q.12 angle
   function automatic void rotate_unit(input longint phi, output longint sn,
                                       output longint cs);
      longint x, y, nx, ny, pi_a, half_a;
      bit flip;
      x = GAIN_Q30;
      y = 0;
      flip = 0;
      pi_a = PI_Q30_L >>> 18;
      half_a = HALF_PI_L >>> 18;
      if (phi > pi_a) phi = phi - 2 * pi_a;
      if (phi > pi_a) phi = phi - 2 * pi_a;
      if (phi < -pi_a) phi = phi + 2 * pi_a;
      if (phi < -pi_a) phi = phi + 2 * pi_a;
      if (phi > half_a) begin
         phi = phi - pi_a; flip = 1;
      end else if (phi < -half_a) begin
         phi = phi + pi_a; flip = 1;
      end
      for (int i = 0; i < STEPS; i++) begin
         if (phi >= 0) begin
            nx = x - (y >>> i); ny = y + (x >>> i); phi = phi - (atan_q30[i] >>> 18);
         end else begin
            nx = x + (y >>> i); ny = y - (x >>> i); phi = phi + (atan_q30[i] >>> 18);
         end
         x = nx;
         y = ny;
      end
      cs = flip ? -x : x;
      sn = flip ? -y : y;
   endfunction

   function automatic logic signed [OUT_W-1:0] base_angle_of(
         input logic signed [COORD_W-1:0] hx_in, input logic signed [COORD_W-1:0] hy_in);
      longint hx, hy, dx, dy, h, a_fore, a_hand, num, den, m, c, side, sn, cs, ex, ey, a;
      hx = hx_in;
      hy = hy_in;
      dx = hx - base_x;
      dy = hy - base_y;
      h = sqrt_floor(dx * dx + dy * dy);
      a_fore = atan2_q12(dx, -dy);
      num = h * h + fore_len * fore_len - upper_len * upper_len;
      den = 2 * h * fore_len;
      if (den == 0) begin
         c = (num >= 0) ? UNIT_Q30 : -UNIT_Q30;
      end else if (num >= den) begin
         c = UNIT_Q30;
      end else if (num <= -den) begin
         c = -UNIT_Q30;
      end else begin
         m = mag(num);
         while (den >= (64'sd1 <<< 33)) begin
            den = den >>> 1;
            m = m >>> 1;
         end
         c = (m <<< 30) / den;
         if (num < 0) c = -c;
      end
      side = sqrt_floor((64'sd1 <<< 60) - c * c);
      a_hand = atan2_q12(side, c);
      rotate_unit(a_fore - a_hand, sn, cs);
      ex = hx - ((fore_len * sn + (64'sd1 <<< 29)) >>> 30);
      ey = hy + ((fore_len * cs + (64'sd1 <<< 29)) >>> 30);
      a = atan2_q12(ey - base_y, ex - base_x);
      if (a > angle_hi) a = angle_hi;
      else if (a < angle_lo) a = angle_lo;
      return a[OUT_W-1:0];
   endfunction

   always @(posedge clock) begin
      logic signed [OUT_W-1:0] want;
      if (reset) begin
         base_x = 0;
         base_y = 0;
         upper_len = 25600;
         fore_len = 25600;
         angle_hi = 12868;
         angle_lo = -12868;
         angle_q.delete();
         errors = 0;
         reports = 0;
         checked = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               REG_BASE_X:    base_x = longint'($signed(pwdata[COORD_W-1:0]));
               REG_BASE_Y:    base_y = longint'($signed(pwdata[COORD_W-1:0]));
               REG_UPPER_LEN: upper_len = longint'(pwdata[LEN_W-1:0]);
               REG_FORE_LEN:  fore_len = longint'(pwdata[LEN_W-1:0]);
               REG_ANGLE_MAX: angle_hi = longint'($signed(pwdata[OUT_W-1:0]));
               REG_ANGLE_MIN: angle_lo = longint'($signed(pwdata[OUT_W-1:0]));
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            angle_q.push_back(base_angle_of(req_hand_x, req_hand_y));
         if (rsp_valid && !rsp_stall) begin
            if (angle_q.size() == 0) begin
               errors++;
               if (reports < 10) begin
                  reports++;
                  $display("unexpected transaction: base_angle %0d", rsp_base_angle);
               end
            end else begin
               want = angle_q.pop_front();
               checked++;
               if (rsp_base_angle !== want) begin
                  errors++;
                  if (reports < 10) begin
                     reports++;
                     $display("base_angle mismatch: expected %0d, got %0d", want,
                              rsp_base_angle);
                  end
               end
            end
         end
      end
      pending = angle_q.size();
   end

endmodule

// ----- verif/testbench.sv -----
// Top of the inverse kinematics testbench: clock, reset, register writes and
// hand point stimulus. Depends on tlik_pkg, the block and ik_checker.
module testbench;
   import tlik_pkg::*;

   localparam int LIMIT = 400000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic signed [COORD_W-1:0] req_hand_x = '0;
   logic signed [COORD_W-1:0] req_hand_y = '0;
   logic rsp_stall = 0;
   logic psel = 0;
   logic penable = 0;
   logic pwrite = 0;
   logic [PADDR_W-1:0] paddr = '0;
   logic [PDATA_W-1:0] pwdata = '0;
   logic req_stall, rsp_valid, pready;
   logic signed [OUT_W-1:0] rsp_base_angle;
   logic [PDATA_W-1:0] prdata;
   int errors, pending, checked;
   int send_idle = 0;
   int rcv_idle = 0;
   int cycles = 0;
   int sent = 0;
   int writes = 0;
   int cur_base_x, cur_base_y, cur_upper, cur_fore;

   two_link_leg_inverse_kinematics_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_hand_x(req_hand_x), .req_hand_y(req_hand_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_base_angle(rsp_base_angle),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready));

   ik_checker angle_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_hand_x(req_hand_x), .req_hand_y(req_hand_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_base_angle(rsp_base_angle),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata),
      .errors(errors), .pending(pending), .checked(checked));

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rcv_idle);
      cycles++;
      if (cycles > LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic int srand(input int r);
      return int'($urandom_range(0, 2 * r)) - r;
   endfunction

   task automatic csr_write(input logic [2:0] idx, input int value);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= PADDR_W'(idx) << 2;
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      writes++;
      case (idx)
         REG_BASE_X:    cur_base_x = value;
         REG_BASE_Y:    cur_base_y = value;
         REG_UPPER_LEN: cur_upper = value;
         REG_FORE_LEN:  cur_fore = value;
         default: ;
      endcase
   endtask

   task automatic write_all(input int bx, input int by, input int ul, input int fl,
                            input int amax, input int amin);
      csr_write(REG_BASE_X, bx);
      csr_write(REG_BASE_Y, by);
      csr_write(REG_UPPER_LEN, ul);
      csr_write(REG_FORE_LEN, fl);
      csr_write(REG_ANGLE_MAX, amax);
      csr_write(REG_ANGLE_MIN, amin);
   endtask

   task automatic send(input int hx, input int hy);
      if ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1;
      req_hand_x <= hx[COORD_W-1:0];
      req_hand_y <= hy[COORD_W-1:0];
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   // hold the input until every prediction has been matched
   task automatic drain();
      req_valid <= 0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   task automatic random_item();
      int r, pick;
      r = cur_upper + cur_fore;
      pick = $urandom_range(0, 9);
      if (pick < 6)
         send(cur_base_x + srand(r), cur_base_y + srand(r));
      else if (pick < 8)
         send(cur_base_x + srand(64), cur_base_y + srand(64));
      else
         send(int'($urandom), int'($urandom));
   endtask

   task automatic random_config();
      write_all(srand(1 << 20), srand(1 << 20), $urandom_range(1, 1 << 17),
                $urandom_range(1, 1 << 17), srand(12868), srand(12868));
   endtask

   initial begin
      cur_base_x = 0;
      cur_base_y = 0;
      cur_upper = 25600;
      cur_fore = 25600;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset settings: hand at base, fully stretched, out of reach, extremes
      send(0, 0);
      send(0, -51200);
      send(25600, -25600);
      send(0, -25600);
      send(8388607, 8388607);
      send(-8388608, -8388608);
      send(8388607, -8388608);
      send(-8388608, 8388607);
      send(-100, 50);
      drain();

      // extreme base, tiny upper link, huge fore link, inverted limits
      write_all(8388607, -8388608, 1, 8388607, -12868, 12868);
      send(8388607, -8388608);
      send(-8388608, 8388607);
      send(0, 0);
      send(8388607, 8388607);
      drain();

      write_all(-8388608, 8388607, 8388607, 1, 12868, -12868);
      send(-8388608, 8388607);
      send(8388607, -8388608);
      send(-8388607, 8388606);
      send(0, 0);
      drain();

      // narrow window around zero; fore link longer than the upper link
      write_all(-25600, 0, 10000, 20000, 3000, -3000);
      send(-25600, -20000);
      send(-25600, -30000);
      send(-5600, 0);
      send(-45600, 0);
      send(-25600, 20000);
      drain();

      send_idle = 17;
      rcv_idle = 81;
      random_config();
      repeat (65) random_item();
      drain();
      random_config();
      repeat (65) random_item();
      drain();

      send_idle = 81;
      rcv_idle = 17;
      random_config();
      repeat (130) random_item();
      drain();

      send_idle = 0;
      rcv_idle = 0;
      random_config();
      repeat (130) random_item();
      drain();

      repeat (200) @(posedge clock);
      $display("covered %0d hand points over %0d register writes, %0d results checked",
               sent, writes, checked);
      if (errors == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/tlik_pkg.sv
hdl/tlik_delay.sv
hdl/tlik_sqrt.sv
hdl/tlik_div.sv
hdl/tlik_vec.sv
hdl/tlik_rot.sv
hdl/two_link_leg_inverse_kinematics_top.sv
hdl/tlik_checker.sv
verif/ik_checker.sv
verif/testbench.sv
